FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the console bus decoder.
// Clocked, reset-qualified property wrappers; no other content.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cmid_pkg.sv
// Shared types and constants for the console memory and I/O decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmid_pkg;

    localparam int RAM_BYTES_DEF      = 1024;
    localparam int CART_ADDR_BITS_DEF = 20;

    localparam int ROM_ADDR_W = 20;
    localparam int CFG_W      = 13;
    localparam int PAGE_W     = 6;

    // Access kinds (stream tuser)
    typedef enum logic [1:0] {
        KIND_MEM_RD = 2'd0,
        KIND_MEM_WR = 2'd1,
        KIND_IO_RD  = 2'd2,
        KIND_IO_WR  = 2'd3
    } kind_t;

    // Result routes
    typedef enum logic [3:0] {
        RT_HERE    = 4'd0,
        RT_BIOS    = 4'd1,
        RT_CART    = 4'd2,
        RT_VDP_DRD = 4'd3,
        RT_VDP_SRD = 4'd4,
        RT_VDP_DWR = 4'd5,
        RT_VDP_CWR = 4'd6,
        RT_PSG     = 4'd7,
        RT_NONE    = 4'd8
    } route_t;

    // Memory map
    localparam logic [15:0] BIOS_END      = 16'h2000;
    localparam logic [15:0] RAM_BASE      = 16'h6000;
    localparam logic [15:0] CART_BASE     = 16'h8000;
    localparam logic [15:0] CART_HI_BASE  = 16'hC000;
    localparam logic [15:0] BANK_SEL_BASE = 16'hFFC0;
    localparam logic [15:0] BANK_BYTES    = 16'h4000;
    localparam logic [CFG_W-1:0] PAGED_BLOCKS = 13'd128;

    // Port groups, port[7:5]
    localparam logic [2:0] GRP_MODE_JOY = 3'b100;  // 0x80
    localparam logic [2:0] GRP_VDP      = 3'b101;  // 0xA0
    localparam logic [2:0] GRP_MODE_KEY = 3'b110;  // 0xC0
    localparam logic [2:0] GRP_PAD      = 3'b111;  // 0xE0

    localparam logic [7:0] PAD_MASK   = 8'h7F;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    // APB register index, taken from paddr[2]
    localparam logic REG_CART_BLOCKS = 1'b0;

    // One decoded word in flight
    typedef struct packed {
        route_t                  route;
        logic [7:0]              data;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic                    ram_rd;   // data comes from work RAM
    } pipe_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cmid_sdp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cmid_sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/cmid_access.sv
// Access decoder: memory map, bank select, port routing, controller mode.
// Depends on cmid_pkg. Holds bank_page and keypad_mode.
`timescale 1ns / 1ps
`default_nettype none

module cmid_access
    import cmid_pkg::*;
#(
    parameter int RAM_BYTES      = RAM_BYTES_DEF,
    parameter int CART_ADDR_BITS = CART_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire kind_t                        kind,
    input  wire logic [15:0]                  address,
    input  wire logic [7:0]                   write_data,
    input  wire logic [15:0]                  pad0_bits,
    input  wire logic [15:0]                  pad1_bits,
    input  wire logic [CFG_W-1:0]             cart_blocks,
    output pipe_t                             item,
    output logic                              ram_we,
    output logic                              ram_re,
    output logic [$clog2(RAM_BYTES)-1:0]      ram_addr,
    output logic [7:0]                        ram_wdata
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int CAB    = CART_ADDR_BITS;

    logic              keypad_mode_reg, keypad_mode_next;
    logic [PAGE_W-1:0] bank_page_reg, bank_page_next;

    logic              paged;
    logic              is_mem;
    logic              bank_sel;
    logic [6:0]        bank_mask;
    logic [PAGE_W-1:0] page;
    logic [20:0]       cb_bytes;
    logic [CAB-1:0]    off_fixed;
    logic [CAB-1:0]    off_paged;
    logic [CAB-1:0]    off_flat;
    logic [2:0]        group;
    logic [15:0]       pad_bits;
    logic [7:0]        pad_byte;
    logic              in_ram;

    assign paged     = cart_blocks > PAGED_BLOCKS;
    assign is_mem    = (kind == KIND_MEM_RD) || (kind == KIND_MEM_WR);
    assign bank_sel  = paged && is_mem && (address >= BANK_SEL_BASE);
    // bank count is cart_blocks >> 6; at least 2 once paging is on
    assign bank_mask = cart_blocks[12:6] - 7'd1;
    assign page      = bank_sel ? (address[PAGE_W-1:0] & bank_mask[PAGE_W-1:0])
                                : bank_page_reg;

    // fixed window shows the last 16 KB bank; offsets wrap at CAB bits
    assign cb_bytes  = {cart_blocks, 8'h00};
    assign off_fixed = cb_bytes[CAB-1:0] - CAB'(BANK_BYTES) + CAB'(address[13:0]);
    assign off_paged = CAB'({page, address[13:0]});
    assign off_flat  = CAB'(address[14:0]);

    assign in_ram    = (address >= RAM_BASE) && (address < CART_BASE);
    assign group     = address[7:5];
    assign pad_bits  = address[1] ? pad1_bits : pad0_bits;
    assign pad_byte  = keypad_mode_reg ? pad_bits[15:8] : pad_bits[7:0];

    always_comb
    begin
        item             = '0;
        item.route       = RT_NONE;
        keypad_mode_next = keypad_mode_reg;
        bank_page_next   = bank_sel ? page : bank_page_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        unique case (kind)
            KIND_MEM_RD:
            begin
                if (address < BIOS_END)
                begin
                    item.route       = RT_BIOS;
                    item.rom_address = ROM_ADDR_W'(address[12:0]);
                end
                else if (address < RAM_BASE)
                begin
                    item.route = RT_HERE;
                end
                else if (address < CART_BASE)
                begin
                    item.route  = RT_HERE;
                    item.ram_rd = 1'b1;
                    ram_re      = accept;
                end
                else if (paged)
                begin
                    item.route       = RT_CART;
                    item.rom_address = ROM_ADDR_W'((address < CART_HI_BASE) ? off_fixed
                                                                           : off_paged);
                end
                else if (CFG_W'(address[14:8]) < cart_blocks)
                begin
                    item.route       = RT_CART;
                    item.rom_address = ROM_ADDR_W'(off_flat);
                end
                else
                begin
                    item.route = RT_HERE;
                end
            end
            KIND_MEM_WR:
            begin
                if (in_ram)
                begin
                    item.route = RT_HERE;
                    item.data  = write_data;
                    ram_we     = accept;
                end
            end
            KIND_IO_RD:
            begin
                unique case (group)
                    GRP_VDP:
                    begin
                        item.route = address[0] ? RT_VDP_SRD : RT_VDP_DRD;
                    end
                    GRP_PAD:
                    begin
                        item.route = RT_HERE;
                        item.data  = ~pad_byte & PAD_MASK;
                    end
                    default:
                    begin
                        item.route = RT_HERE;
                        item.data  = OPEN_BUS;
                    end
                endcase
            end
            KIND_IO_WR:
            begin
                unique case (group)
                    GRP_VDP:
                    begin
                        item.route = address[0] ? RT_VDP_CWR : RT_VDP_DWR;
                        item.data  = write_data;
                    end
                    GRP_MODE_JOY: keypad_mode_next = 1'b0;
                    GRP_MODE_KEY: keypad_mode_next = 1'b1;
                    GRP_PAD:
                    begin
                        item.route = RT_PSG;
                        item.data  = write_data;
                    end
                    default: item.route = RT_NONE;
                endcase
            end
            default: item.route = RT_NONE;
        endcase
    end

    assign ram_addr  = address[RAM_AW-1:0];
    assign ram_wdata = write_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keypad_mode_reg <= 1'b0;
            bank_page_reg   <= '0;
        end
        else if (accept)
        begin
            keypad_mode_reg <= keypad_mode_next;
            bank_page_reg   <= bank_page_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/console_memory_and_io_decoder.sv
// Console memory and I/O decoder: one CPU bus access per word, 1 word/cycle while s_axis_tready is high.
// A taken word is registered in p1, then in out, whose valid bit drives m_axis_tvalid.
// Throughput: one word per cycle while the result side does not stall, bounded by the single work RAM port pair.
// Reset: rst_n clears bank page, keypad mode and cart_blocks at once; the work
// RAM is then zeroed by a sweep over every address, with s_axis_tready
// low meanwhile. APB writes are taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module console_memory_and_io_decoder
    import cmid_pkg::*;
#(
    parameter int RAM_BYTES      = RAM_BYTES_DEF,
    parameter int CART_ADDR_BITS = CART_ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] address, [23:16] write_data, [39:24] pad0_bits, [55:40] pad1_bits
    input  wire logic [55:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_data, [27:8] rom_address, [31:28] zero
    output logic [31:0]      m_axis_tdata,
    // [3:0] route
    output logic [3:0]       m_axis_tuser,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cart_blocks_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CART_BLOCKS) ? 32'(cart_blocks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_blocks_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_CART_BLOCKS))
        begin
            cart_blocks_reg <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Post-reset RAM sweep
    // ------------------------------------------------------------------
    logic              clear_active_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clr_cnt_reg      <= '0;
        end
        else if (clear_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {RAM_AW{1'b1}})
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    //   stage 1 (p1): decoded word, RAM read in flight
    //   stage 2 (out): result register facing the master side
    // ------------------------------------------------------------------
    logic  s_accept;
    logic  p1_move;
    logic  pipe_stalled;
    logic  p1_valid_reg, p1_valid_next;
    logic  out_valid_reg, out_valid_next;
    pipe_t p1_reg;
    pipe_t out_reg;
    pipe_t out_load;
    pipe_t item;

    assign p1_move       = p1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clear_active_reg && (!p1_valid_reg || p1_move);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pipe_stalled  = p1_valid_reg && out_valid_reg && !m_axis_tready;

    // ------------------------------------------------------------------
    // Decode and work RAM
    // ------------------------------------------------------------------
    logic              acc_we;
    logic              acc_re;
    logic [RAM_AW-1:0] acc_addr;
    logic [7:0]        acc_wdata;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    cmid_access #(
        .RAM_BYTES      (RAM_BYTES),
        .CART_ADDR_BITS (CART_ADDR_BITS)
    ) u_access (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .kind        (kind_t'(s_axis_tuser)),
        .address     (s_axis_tdata[15:0]),
        .write_data  (s_axis_tdata[23:16]),
        .pad0_bits   (s_axis_tdata[39:24]),
        .pad1_bits   (s_axis_tdata[55:40]),
        .cart_blocks (cart_blocks_reg),
        .item        (item),
        .ram_we      (acc_we),
        .ram_re      (acc_re),
        .ram_addr    (acc_addr),
        .ram_wdata   (acc_wdata)
    );

    // Writes land at the accept edge and reads are issued at the accept
    // edge too, so a later read always sees an earlier write: no forwarding.
    assign ram_we    = clear_active_reg || acc_we;
    assign ram_waddr = clear_active_reg ? clr_cnt_reg : acc_addr;
    assign ram_wdata = clear_active_reg ? 8'h00 : acc_wdata;

    // Read data register holds while p1 stalls, since no new read is issued.
    cmid_sdp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc_re),
        .raddr (acc_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_comb
    begin
        p1_valid_next  = p1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_next = 1'b0;
        end
        if (p1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // RAM reads pick up the registered read data on the way out
    always_comb
    begin
        out_load      = p1_reg;
        out_load.data = p1_reg.ram_rd ? ram_rdata : p1_reg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_reg <= item;
        end
        if (p1_move)
        begin
            out_reg <= out_load;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.rom_address, out_reg.data};
    assign m_axis_tuser  = out_reg.route;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_sweep_blocks_in, clk, rst_n, clear_active_reg, !s_axis_tready, "word in sweep")
    `ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, pipe_stalled, !s_axis_tready, "taken on stall")
    `ASSERT_IMPL(a_ram_we_src, clk, rst_n, ram_we, clear_active_reg || s_accept, "stray RAM write")
    `ASSERT_NEXT(a_accept_fills_p1, clk, rst_n, s_accept, p1_valid_reg, "word lost before p1")

endmodule

`default_nettype wire

FILE: test/bus_decode_checker.sv
// Scoreboard for the console bus decoder: keeps its own copy of the memory map
// state, predicts the decode of every accepted word and checks the result stream.
// Depends on cmid_pkg for the access kinds, routes and memory map constants.
`timescale 1ns / 1ps

module bus_decode_checker
    import cmid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [15:0] address, [23:16] write_data, [39:24] pad0_bits, [55:40] pad1_bits
    input  logic [55:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_data, [27:8] rom_address, [31:28] zero
    input  logic [31:0] m_axis_tdata,
    // [3:0] route
    input  logic [3:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    localparam int          RAM_IDX_W = $clog2(RAM_BYTES_DEF);
    localparam logic [31:0] CART_MASK = (32'd1 << CART_ADDR_BITS_DEF) - 32'd1;

    typedef struct packed {
        route_t                route;
        logic [7:0]            data;
        logic [ROM_ADDR_W-1:0] rom_address;
    } decode_t;

    logic [7:0]        ram_image [RAM_BYTES_DEF];
    logic              keypad_sel;
    logic [PAGE_W-1:0] hi_bank;
    logic [CFG_W-1:0]  cart_size;
    decode_t           decodes_due [$];

    initial mismatches = 0;

    function automatic decode_t pack_result(input route_t rt, input logic [7:0] d,
                                            input logic [31:0] rom);
        decode_t r;
        r.route       = rt;
        r.data        = d;
        r.rom_address = rom[ROM_ADDR_W-1:0];
        return r;
    endfunction

    // Memory read decode with the current bank
    function automatic decode_t mem_fetch(input logic [15:0] addr);
        logic [31:0] off;
        if (addr < BIOS_END)
            return pack_result(RT_BIOS, 8'h00, 32'(addr));
        if (addr < RAM_BASE)
            return pack_result(RT_HERE, 8'h00, 32'd0);
        if (addr < CART_BASE)
            return pack_result(RT_HERE, ram_image[addr[RAM_IDX_W-1:0]], 32'd0);
        if (cart_size > PAGED_BLOCKS)
        begin
            if (addr < CART_HI_BASE)
                off = (32'(cart_size) << 8) - 32'(BANK_BYTES) + 32'(addr[13:0]);
            else
                off = (32'(hi_bank) << 14) + 32'(addr[13:0]);
            return pack_result(RT_CART, 8'h00, off & CART_MASK);
        end
        off = 32'(addr - CART_BASE);
        if ((off >> 8) < 32'(cart_size))
            return pack_result(RT_CART, 8'h00, off & CART_MASK);
        return pack_result(RT_HERE, 8'h00, 32'd0);
    endfunction

    // Full decode of one bus word; updates RAM, bank and controller mode
    function automatic decode_t decode_access(input kind_t kind, input logic [15:0] addr,
                                              input logic [7:0] wdata,
                                              input logic [15:0] pad0,
                                              input logic [15:0] pad1);
        logic [7:0]  port;
        logic [15:0] pad;
        logic [7:0]  pressed;
        logic [31:0] banks;
        port = addr[7:0];
        if ((kind == KIND_MEM_RD || kind == KIND_MEM_WR) && cart_size > PAGED_BLOCKS
                && addr >= BANK_SEL_BASE)
        begin
            banks   = 32'(cart_size) >> 6;
            hi_bank = PAGE_W'(32'(addr) & (banks - 32'd1));
        end
        case (kind)
            KIND_MEM_RD: return mem_fetch(addr);
            KIND_MEM_WR:
            begin
                if (addr >= RAM_BASE && addr < CART_BASE)
                begin
                    ram_image[addr[RAM_IDX_W-1:0]] = wdata;
                    return pack_result(RT_HERE, wdata, 32'd0);
                end
                return pack_result(RT_NONE, 8'h00, 32'd0);
            end
            KIND_IO_RD:
            begin
                if (port[7:5] == GRP_VDP)
                    return pack_result(port[0] ? RT_VDP_SRD : RT_VDP_DRD, 8'h00, 32'd0);
                if (port[7:5] == GRP_PAD)
                begin
                    pad     = port[1] ? pad1 : pad0;
                    pressed = keypad_sel ? pad[15:8] : pad[7:0];
                    return pack_result(RT_HERE, ~pressed & PAD_MASK, 32'd0);
                end
                return pack_result(RT_HERE, OPEN_BUS, 32'd0);
            end
            default:
            begin
                case (port[7:5])
                    GRP_VDP:
                        return pack_result(port[0] ? RT_VDP_CWR : RT_VDP_DWR, wdata, 32'd0);
                    GRP_PAD:      return pack_result(RT_PSG, wdata, 32'd0);
                    GRP_MODE_JOY: keypad_sel = 1'b0;
                    GRP_MODE_KEY: keypad_sel = 1'b1;
                    default:      ;
                endcase
                return pack_result(RT_NONE, 8'h00, 32'd0);
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t decoder mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decode_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_BYTES_DEF; i++)
                ram_image[i] = 8'h00;
            keypad_sel = 1'b0;
            hi_bank    = '0;
            cart_size  = '0;
            decodes_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CART_BLOCKS)
                cart_size = pwdata[CFG_W-1:0];
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decodes_due.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected word, route %0d", m_axis_tuser));
                end
                else
                begin
                    want = decodes_due.pop_front();
                    if (m_axis_tuser !== want.route)
                        note_mismatch($sformatf("route %0d, want %0d",
                                                m_axis_tuser, want.route));
                    if (m_axis_tdata[7:0] !== want.data)
                        note_mismatch($sformatf("out_data %h, want %h",
                                                m_axis_tdata[7:0], want.data));
                    if (m_axis_tdata[27:8] !== want.rom_address)
                        note_mismatch($sformatf("rom_address %h, want %h",
                                                m_axis_tdata[27:8], want.rom_address));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decodes_due.push_back(decode_access(kind_t'(s_axis_tuser),
                                                    s_axis_tdata[15:0], s_axis_tdata[23:16],
                                                    s_axis_tdata[39:24], s_axis_tdata[55:40]));
            outstanding <= decodes_due.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// Top of the console bus decoder testbench: clock, reset, bus word stimulus,
// APB configuration and the verdict. Depends on cmid_pkg, the decoder RTL and
// bus_decode_checker.
`timescale 1ns / 1ps

module tb_top
    import cmid_pkg::*;
();

    // Byte addresses of the config register and of an unused slot
    localparam logic [2:0] CART_BLOCKS_ADDR = {REG_CART_BLOCKS, 2'b00};
    localparam logic [2:0] SPARE_ADDR       = {~REG_CART_BLOCKS, 2'b00};

    localparam int SEGMENTS          = 12;
    localparam int WORDS_PER_SEGMENT = 104;
    localparam int FIXED_SETTINGS    = 10;
    // Cart sizes per segment: extremes, the paging threshold either side,
    // odd bank counts and a tiny unpaged cart; the last segments pick at random
    localparam int BLOCK_SETTINGS [FIXED_SETTINGS] =
        '{0, 4096, 128, 129, 200, 64, 1024, 4095, 191, 1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] address, [23:16] write_data, [39:24] pad0_bits, [55:40] pad1_bits
    logic [55:0] s_axis_tdata = '0;
    // [1:0] kind
    logic [1:0]  s_axis_tuser = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] out_data, [27:8] rom_address, [31:28] zero
    logic [31:0] m_axis_tdata;
    // [3:0] route
    logic [3:0]  m_axis_tuser;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;

    // Idle rates in percent for the two sides of the stream
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    // Last cart size written, used to aim accesses at the end of the cart
    logic [CFG_W-1:0] cart_blocks_now = '0;

    always #6 clk = ~clk;

    console_memory_and_io_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bus_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side back-pressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Setup then access phase; the task waits with psel deselected before it returns, so that two
    // back-to-back writes never drive psel twice in one step
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CART_BLOCKS_ADDR)
            cart_blocks_now = value[CFG_W-1:0];
        @(posedge clk);
    endtask

    // Offer one bus word, after a random gap, and hold it until taken.
    // tvalid stays high into the next word when no gap is drawn.
    task automatic send_word(input kind_t kind, input logic [15:0] addr,
                             input logic [7:0] wdata, input logic [15:0] pad0,
                             input logic [15:0] pad1);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pad1, pad0, wdata, addr};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every predicted result has come out.
    // The first edge is always taken so a word accepted just now is counted.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Random word, biased towards the interesting parts of the memory map
    task automatic random_word();
        kind_t       kind;
        logic [15:0] addr;
        kind = kind_t'($urandom_range(0, 3));
        addr = 16'($urandom_range(0, 16'hFFFF));
        if (kind == KIND_MEM_RD || kind == KIND_MEM_WR)
        begin
            case ($urandom_range(0, 9))
                0: addr = 16'($urandom_range(0, BIOS_END - 1));
                1: addr = 16'($urandom_range(BIOS_END, RAM_BASE - 1));
                2, 3, 4:
                begin
                    // RAM with all mirrors; half the time a 16 byte hot spot
                    // so that reads find earlier writes
                    addr = RAM_BASE | 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(0, 1) == 1)
                        addr[9:4] = '0;
                end
                5: addr = 16'($urandom_range(CART_BASE, CART_HI_BASE - 1));
                6: addr = 16'($urandom_range(CART_HI_BASE, BANK_SEL_BASE - 1));
                7: addr = 16'($urandom_range(BANK_SEL_BASE, 16'hFFFF));
                8: addr = CART_BASE + {cart_blocks_now[7:0], 8'h00} - 16'd8
                          + 16'($urandom_range(0, 15));
                default: ;
            endcase
        end
        send_word(kind, addr, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Corners of the map and of every port group, with no cart fitted first
    task automatic directed_words();
        send_word(KIND_MEM_RD, 16'h0000, 8'h00, 16'h0000, 16'h0000);  // BIOS bottom
        send_word(KIND_MEM_RD, 16'h1FFF, 8'hFF, 16'hFFFF, 16'hFFFF);  // BIOS top
        send_word(KIND_MEM_RD, 16'h2000, 8'h00, 16'h0000, 16'h0000);  // hole start
        send_word(KIND_MEM_RD, 16'h5FFF, 8'h00, 16'h0000, 16'h0000);  // hole end
        send_word(KIND_MEM_RD, 16'h6000, 8'h00, 16'h0000, 16'h0000);  // RAM cleared
        send_word(KIND_MEM_WR, 16'h63FF, 8'hFF, 16'h0000, 16'h0000);  // RAM top byte
        send_word(KIND_MEM_RD, 16'h7FFF, 8'h00, 16'h0000, 16'h0000);  // its last mirror
        send_word(KIND_MEM_WR, 16'h0000, 8'hA5, 16'h0000, 16'h0000);  // ROM write dropped
        send_word(KIND_MEM_RD, 16'h8000, 8'h00, 16'h0000, 16'h0000);  // no cart
        send_word(KIND_IO_RD,  16'h00A0, 8'h00, 16'h0000, 16'h0000);  // VDP data
        send_word(KIND_IO_RD,  16'hFFA1, 8'h00, 16'h0000, 16'h0000);  // VDP status
        send_word(KIND_IO_WR,  16'h00A0, 8'h5A, 16'h0000, 16'h0000);
        send_word(KIND_IO_WR,  16'h00BF, 8'hC3, 16'h0000, 16'h0000);  // VDP control
        send_word(KIND_IO_WR,  16'h00FF, 8'h9F, 16'h0000, 16'h0000);  // PSG
        send_word(KIND_IO_RD,  16'h00E0, 8'h00, 16'h0000, 16'hFFFF);  // pad 0, joystick
        send_word(KIND_IO_WR,  16'h00C0, 8'h00, 16'h0000, 16'h0000);  // keypad mode on
        send_word(KIND_IO_RD,  16'hFFFF, 8'h00, 16'h0000, 16'hFFFF);  // pad 1, keypad
        send_word(KIND_IO_WR,  16'h009F, 8'h00, 16'h0000, 16'h0000);  // joystick mode
        send_word(KIND_IO_RD,  16'h00FD, 8'h00, 16'hFF00, 16'h00FF);  // pad 0 again
        send_word(KIND_IO_RD,  16'h0000, 8'h00, 16'h0000, 16'h0000);  // open bus read
        send_word(KIND_IO_WR,  16'h007F, 8'h77, 16'h0000, 16'h0000);  // write to nothing
        drain();
        // Largest cart, 64 banks; a write to the unused slot must change nothing
        apb_write(CART_BLOCKS_ADDR, 32'd4096);
        apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
        send_word(KIND_MEM_RD, 16'h8000, 8'h00, 16'h0000, 16'h0000);  // fixed last bank
        send_word(KIND_MEM_RD, 16'hFFFF, 8'h00, 16'h0000, 16'h0000);  // select bank 63
        send_word(KIND_MEM_WR, 16'hFFC0, 8'h11, 16'h0000, 16'h0000);  // select bank 0
        send_word(KIND_MEM_RD, 16'hC000, 8'h00, 16'h0000, 16'h0000);
        send_word(KIND_MEM_RD, 16'hBFFF, 8'h00, 16'h0000, 16'h0000);
    endtask

    initial
    begin
        int seg_blocks;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Config is taken during the RAM clearing sweep
        apb_write(CART_BLOCKS_ADDR, 32'd0);
        directed_words();
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < FIXED_SETTINGS)
                seg_blocks = BLOCK_SETTINGS[seg];
            else
                seg_blocks = $urandom_range(0, 4096);
            apb_write(CART_BLOCKS_ADDR, 32'(seg_blocks));

            // Rotate: no idling, sparse sender, slow receiver, both idling
            case (seg % 4)
                0:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_gap_pct = 88;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct <= 88;
                end
                default:
                begin
                    send_gap_pct = 34;
                    recv_stall_pct <= 34;
                end
            endcase

            for (int n = 0; n < WORDS_PER_SEGMENT; n++)
            begin
                // Mid-segment pause until the pipe is empty
                if (n == WORDS_PER_SEGMENT / 2 && seg % 4 == 2)
                    drain();
                random_word();
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cmid_pkg.sv
hw/rtl/cmid_sdp_ram.sv
hw/rtl/cmid_access.sv
hw/rtl/console_memory_and_io_decoder.sv
test/bus_decode_checker.sv
test/tb_top.sv
